// ----- hw/rtl/gfla_pkg.sv -----
package gfla_pkg;

  // table geometry
  localparam int NUM_LOCKS   = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int LW     = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
  localparam int QW     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QMEM_DEPTH = NUM_LOCKS * (2 ** QW);

  localparam logic [6:0] FAVOR_MAX = 7'd100;

  // request kinds
  localparam logic [1:0] REQ_CREATE  = 2'd0;
  localparam logic [1:0] REQ_ACQUIRE = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_DESTROY = 2'd3;

  // one queued waiter
  typedef struct packed {
    logic [5:0] proc;
    logic [7:0] grp;
  } waiter_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_SHIFT = 3'b100
  } state_t;

endpackage

// ----- hw/rtl/group_favoring_lock_arbiter.sv -----
// Lock table with per-lock FIFO wait queues held in one synchronous memory
// (one read, one write port, registered read data). Create, acquire,
// destroy and a release with an empty queue or in error finish in idle:
// busy stays low and the result strobe follows the accepting edge. A
// release with n waiters scans the queue one entry a cycle until the first
// same-group waiter, then compacts the entries behind the chosen one one a
// cycle. The receiver cannot stall: out_valid is high for exactly one cycle
// per accepted beat.
module group_favoring_lock_arbiter import gfla_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [3:0] in_lock_id,
  input  logic [6:0] in_favor_percent,
  input  logic [5:0] in_requester_proc,
  input  logic [7:0] in_requester_group,
  input  logic [6:0] in_random_percent,
  output logic       out_valid,
  output logic       out_status,
  output logic [3:0] out_created_id,
  output logic       out_granted_now,
  output logic       out_queued,
  output logic       out_handoff_valid,
  output logic [5:0] out_handoff_proc,
  output logic       out_handoff_friend
);

  // slot table
  logic [NUM_LOCKS-1:0] active_r, locked_r;
  logic [7:0]       hgrp_r  [NUM_LOCKS];
  logic [6:0]       favor_r [NUM_LOCKS];
  logic [CNT_W-1:0] cnt_r   [NUM_LOCKS];

  // wait queue memory
  waiter_t              wq_mem [QMEM_DEPTH];
  waiter_t              wq_q_r;
  logic [LW+QW-1:0]     wq_raddr, wq_waddr;
  logic                 wq_we;
  waiter_t              wq_wdata;

  state_t state_r;

  // release context
  logic [LW-1:0]    slot_r;
  logic [6:0]       rnd_r;
  logic [CNT_W-1:0] n_r, rd_idx_r;
  logic             chk_vld_r, wr_pend_r;
  logic [QW-1:0]    chk_idx_r, wr_idx_r;
  waiter_t          head_r, chosen_r;
  logic             friend_r;

  // result registers
  logic       out_valid_r, out_status_r, out_granted_r, out_queued_r;
  logic       out_hv_r, out_friend_r;
  logic [3:0] out_cid_r;
  logic [5:0] out_hproc_r;

  logic          accept, id_bad, free_found, hit, last_chk, favor_win;
  logic          scan_issue, sh_issue, scan_done, sh_done;
  logic [LW-1:0] sid, free_idx;
  waiter_t       head_now;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign sid    = LW'(in_lock_id);
  assign id_bad = (int'(in_lock_id) >= NUM_LOCKS) || !active_r[sid];

  // lowest inactive slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = LW'(i);
      end
    end
  end

  // scan and compaction control
  always_comb begin
    hit        = chk_vld_r && (wq_q_r.grp == hgrp_r[slot_r]);
    last_chk   = chk_vld_r && (chk_idx_r == QW'(n_r - CNT_W'(1)));
    scan_issue = (state_r == ST_SCAN) && !hit && (rd_idx_r < n_r);
    scan_done  = (state_r == ST_SCAN) && (hit || last_chk);
    favor_win  = hit && (rnd_r < favor_r[slot_r]);
    head_now   = (chk_idx_r == '0) ? wq_q_r : head_r;
    sh_issue   = (state_r == ST_SHIFT) && (rd_idx_r < n_r);
    sh_done    = (state_r == ST_SHIFT) && !sh_issue && !wr_pend_r;
    wq_raddr   = {slot_r, QW'(rd_idx_r)};
    wq_we      = 1'b0;
    wq_waddr   = {slot_r, wr_idx_r};
    wq_wdata   = wq_q_r;
    if (state_r == ST_SHIFT) begin
      wq_we = wr_pend_r;
    end else if (accept && in_req_type == REQ_ACQUIRE && !id_bad && locked_r[sid] &&
                 int'(cnt_r[sid]) < QUEUE_DEPTH) begin
      wq_we    = 1'b1;
      wq_waddr = {sid, QW'(cnt_r[sid])};
      wq_wdata = '{proc: in_requester_proc, grp: in_requester_group};
    end
  end

  always_ff @(posedge clk) begin
    if (wq_we) wq_mem[wq_waddr] <= wq_wdata;
    wq_q_r <= wq_mem[wq_raddr];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= '0;
      locked_r    <= '0;
      chk_vld_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      for (int i = 0; i < NUM_LOCKS; i++) cnt_r[i] <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            out_status_r  <= 1'b0;
            out_cid_r     <= '0;
            out_granted_r <= 1'b0;
            out_queued_r  <= 1'b0;
            out_hv_r      <= 1'b0;
            out_hproc_r   <= '0;
            out_friend_r  <= 1'b0;
            out_valid_r   <= 1'b1;
            slot_r        <= sid;
            rnd_r         <= in_random_percent;
            n_r           <= cnt_r[sid];
            rd_idx_r      <= '0;
            chk_vld_r     <= 1'b0;
            if (in_req_type == REQ_CREATE) begin
              if (in_favor_percent > FAVOR_MAX || !free_found) begin
                out_status_r <= 1'b1;
              end else begin
                active_r[free_idx] <= 1'b1;
                locked_r[free_idx] <= 1'b0;
                hgrp_r[free_idx]   <= '0;
                favor_r[free_idx]  <= in_favor_percent;
                cnt_r[free_idx]    <= '0;
                out_cid_r          <= 4'(free_idx);
              end
            end else if (id_bad) begin
              out_status_r <= 1'b1;
            end else begin
              case (in_req_type)
                REQ_ACQUIRE: begin
                  if (!locked_r[sid]) begin
                    locked_r[sid] <= 1'b1;
                    hgrp_r[sid]   <= in_requester_group;
                    out_granted_r <= 1'b1;
                  end else if (int'(cnt_r[sid]) >= QUEUE_DEPTH) begin
                    out_status_r <= 1'b1;
                  end else begin
                    cnt_r[sid]   <= cnt_r[sid] + CNT_W'(1);
                    out_queued_r <= 1'b1;
                  end
                end
                REQ_RELEASE: begin
                  if (!locked_r[sid]) begin
                    out_status_r <= 1'b1;
                  end else if (cnt_r[sid] == '0) begin
                    locked_r[sid] <= 1'b0;
                    hgrp_r[sid]   <= '0;
                  end else begin
                    out_valid_r <= 1'b0;
                    state_r     <= ST_SCAN;
                  end
                end
                default: begin
                  active_r[sid] <= 1'b0;
                  locked_r[sid] <= 1'b0;
                  hgrp_r[sid]   <= '0;
                  cnt_r[sid]    <= '0;
                end
              endcase
            end
          end
        end
        ST_SCAN: begin
          // one read issued per cycle, its data checked the next
          chk_vld_r <= scan_issue;
          chk_idx_r <= QW'(rd_idx_r);
          if (scan_issue) rd_idx_r <= rd_idx_r + CNT_W'(1);
          if (chk_vld_r && chk_idx_r == '0) head_r <= wq_q_r;
          if (scan_done) begin
            chk_vld_r <= 1'b0;
            friend_r  <= favor_win;
            chosen_r  <= favor_win ? wq_q_r : head_now;
            rd_idx_r  <= (favor_win ? CNT_W'(chk_idx_r) : '0) + CNT_W'(1);
            wr_pend_r <= 1'b0;
            state_r   <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          // move entry j down to j-1 behind the chosen waiter
          wr_pend_r <= sh_issue;
          wr_idx_r  <= QW'(rd_idx_r - CNT_W'(1));
          if (sh_issue) rd_idx_r <= rd_idx_r + CNT_W'(1);
          if (sh_done) begin
            cnt_r[slot_r]  <= n_r - CNT_W'(1);
            hgrp_r[slot_r] <= chosen_r.grp;
            out_hv_r       <= 1'b1;
            out_hproc_r    <= chosen_r.proc;
            out_friend_r   <= friend_r;
            out_valid_r    <= 1'b1;
            state_r        <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_created_id     = out_cid_r;
  assign out_granted_now    = out_granted_r;
  assign out_queued         = out_queued_r;
  assign out_handoff_valid  = out_hv_r;
  assign out_handoff_proc   = out_hproc_r;
  assign out_handoff_friend = out_friend_r;

endmodule

// ----- hw/rtl/gfla_checker.sv -----
module gfla_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_status,
  input logic [3:0] out_created_id,
  input logic       out_granted_now,
  input logic       out_queued,
  input logic       out_handoff_valid,
  input logic [5:0] out_handoff_proc,
  input logic       out_handoff_friend
);

  // an error beat carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_granted_now && !out_queued && !out_handoff_valid &&
      !out_handoff_friend && out_created_id == '0 && out_handoff_proc == '0)
    else $error("error beat with payload");

  // at most one outcome flag
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({out_granted_now, out_queued, out_handoff_valid}) <= 1)
    else $error("several outcome flags");

  // a favoured handoff is a handoff
  a_friend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_handoff_friend |-> out_handoff_valid)
    else $error("friend without handoff");

  // an accepted beat answers at once or keeps the block busy
  a_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid || busy)
    else $error("accepted beat lost");

endmodule

bind group_favoring_lock_arbiter gfla_checker u_gfla_checker (.*);
